FILE: src/fpr_pkg.sv
// shared types and constants for the framed packet receiver
// no dependencies; imported by every module of the block
`default_nettype none

package fpr_pkg;

   // frame layout
   localparam logic [7:0] HDR0 = 8'hEF;
   localparam logic [7:0] HDR1 = 8'h01;
   localparam int unsigned SUM_START      = 6;   // first summed byte, also the type byte
   localparam int unsigned LEN_HI_IDX     = 7;
   localparam int unsigned LEN_LO_IDX     = 8;
   localparam int unsigned FRAME_OVERHEAD = 9;

   // defaults for top level parameters
   localparam int unsigned MAX_PACKET_DEF  = 128;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // input item kinds
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // result kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // end status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CSUM_ERR  = 2'd1;
   localparam logic [1:0] ST_TIMEOUT   = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   localparam int unsigned RSP_DATA_W = 40;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic [6:0] byte_index;
      logic [1:0] status;
      logic [7:0] packet_total;
      logic [7:0] packet_flag;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/fpr_parser.sv
// front end: frame sync, length check, checksum sum and tick timeout
// depends on fpr_pkg; one item per cycle, pushes at most one result
`default_nettype none

module fpr_parser
   import fpr_pkg::*;
#(
   parameter int unsigned MAX_PACKET = MAX_PACKET_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   input  wire logic        action,
   input  wire logic [7:0]  rx_byte,
   input  wire logic        cfg_write,
   input  wire logic [15:0] cfg_data,
   output      logic        push,
   output      rsp_type     result
);

   localparam int unsigned CNT_W = $clog2(MAX_PACKET);
   localparam int unsigned TOT_W = $clog2(MAX_PACKET + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       len_hi_ff, len_hi_in;
   logic [7:0]       csum_hi_ff, csum_hi_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      sum_ff, sum_in;
   logic [15:0]      tick_ff, tick_in;
   logic [15:0]      timeout_ff, timeout_in;
   logic [CNT_W-1:0] end_idx_ff, end_idx_in;
   logic             len_known_ff, len_known_in;

   logic [15:0]      tick_inc;
   logic [15:0]      len_field;
   logic [16:0]      len_total;
   logic             malformed;
   logic [TOT_W-1:0] total;
   logic             clear;

   assign tick_inc  = (tick_ff == 16'hFFFF) ? tick_ff : tick_ff + 16'd1;
   assign len_field = {len_hi_ff, rx_byte};
   assign len_total = 17'(len_field) + 17'(FRAME_OVERHEAD);
   assign malformed = (len_field < 16'd2) || (len_total > 17'(MAX_PACKET));
   assign total     = TOT_W'(end_idx_ff) + TOT_W'(1);
   assign timeout_in = cfg_write ? cfg_data : timeout_ff;

   always_comb begin
      count_in     = count_ff;
      first_in     = first_ff;
      len_hi_in    = len_hi_ff;
      csum_hi_in   = csum_hi_ff;
      type_in      = type_ff;
      sum_in       = sum_ff;
      tick_in      = tick_ff;
      end_idx_in   = end_idx_ff;
      len_known_in = len_known_ff;
      clear        = 1'b0;
      push         = 1'b0;
      result       = '0;
      if (item_valid) begin
         if (action == ACT_TICK) begin
            tick_in = tick_inc;
            if (tick_inc >= timeout_ff) begin
               push          = 1'b1;
               result.kind   = KIND_END;
               result.status = ST_TIMEOUT;
               clear         = 1'b1;
            end
         end else if (count_ff == CNT_W'(0)) begin
            first_in = rx_byte;
            count_in = CNT_W'(1);
         end else if (count_ff == CNT_W'(1)) begin
            if (first_ff == HDR0 && rx_byte == HDR1) begin
               count_in = CNT_W'(2);
            end else begin
               count_in = '0;
               first_in = '0;
            end
         end else begin
            if (count_ff == CNT_W'(SUM_START)) begin
               type_in = rx_byte;
            end
            if (count_ff == CNT_W'(LEN_HI_IDX)) begin
               len_hi_in = rx_byte;
            end
            if (len_known_ff && count_ff == end_idx_ff) begin
               // last checksum byte closes the packet
               push               = 1'b1;
               result.kind        = KIND_END;
               result.packet_flag = type_ff;
               if ({csum_hi_ff, rx_byte} == sum_ff) begin
                  result.status       = ST_OK;
                  result.packet_total = 8'(total);
               end else begin
                  result.status = ST_CSUM_ERR;
               end
               clear = 1'b1;
            end else if (count_ff == CNT_W'(LEN_LO_IDX) && malformed) begin
               push               = 1'b1;
               result.kind        = KIND_END;
               result.status      = ST_MALFORMED;
               result.packet_flag = type_ff;
               clear              = 1'b1;
            end else begin
               if (count_ff == CNT_W'(LEN_LO_IDX)) begin
                  len_known_in = 1'b1;
                  end_idx_in   = CNT_W'(len_total - 17'd1);
               end
               if (len_known_ff && count_ff == end_idx_ff - CNT_W'(1)) begin
                  csum_hi_in = rx_byte;
               end else if (count_ff >= CNT_W'(SUM_START)) begin
                  sum_in = sum_ff + 16'(rx_byte);
               end
               count_in          = count_ff + CNT_W'(1);
               push              = 1'b1;
               result.kind       = KIND_BYTE;
               result.byte_value = rx_byte;
               result.byte_index = 7'(count_ff);
            end
         end
      end
      if (clear) begin
         count_in     = '0;
         first_in     = '0;
         len_hi_in    = '0;
         csum_hi_in   = '0;
         type_in      = '0;
         sum_in       = '0;
         tick_in      = '0;
         end_idx_in   = '0;
         len_known_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         first_ff     <= '0;
         len_hi_ff    <= '0;
         csum_hi_ff   <= '0;
         type_ff      <= '0;
         sum_ff       <= '0;
         tick_ff      <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         end_idx_ff   <= '0;
         len_known_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         first_ff     <= first_in;
         len_hi_ff    <= len_hi_in;
         csum_hi_ff   <= csum_hi_in;
         type_ff      <= type_in;
         sum_ff       <= sum_in;
         tick_ff      <= tick_in;
         timeout_ff   <= timeout_in;
         end_idx_ff   <= end_idx_in;
         len_known_ff <= len_known_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/fpr_fifo.sv
// short result queue between the parser and the output stage
// depends on fpr_pkg for the result type
`default_nettype none

module fpr_fifo
   import fpr_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   input  wire logic    pop,
   output      logic    full,
   output      logic    not_empty,
   output      rsp_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rsp_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/fpr_out.sv
// back end: output register that drains the queue onto the result stream
// depends on fpr_pkg for the result type and tdata width
`default_nettype none

module fpr_out
   import fpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_not_empty,
   input  wire rsp_type               q_head,
   output      logic                  q_pop,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tuser
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign q_pop    = q_not_empty && (!valid_ff || rsp_tready);
   assign valid_in = q_pop ? 1'b1 : (valid_ff && !rsp_tready);
   assign data_in  = q_pop ? q_head : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.kind;
   assign rsp_tdata  = {7'd0, data_ff.packet_flag, data_ff.packet_total, data_ff.status,
                        data_ff.byte_index, data_ff.byte_value};

endmodule

`default_nettype wire

FILE: src/framed_packet_receiver_top.sv
// framed packet receiver: EF 01 header sync, 16-bit sum checksum, tick timeout
// a result goes from the parser through the result queue and the output register
// throughput: one item per cycle; req_tready drops only while the result queue is full
// reset: synchronous active high, clears parser progress, queue and output register,
// and loads timeout_ticks with 1000
`default_nettype none

module framed_packet_receiver_top
   import fpr_pkg::*;
#(
   parameter int unsigned MAX_PACKET  = MAX_PACKET_DEF,  // largest legal frame in bytes
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF  // result queue entries
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   // input stream: one byte or one millisecond tick per transfer
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] rx_byte
   input  wire logic                  req_tuser,   // [0] action (0 byte, 1 tick)

   // result stream: byte reports and packet end reports
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] byte_value, [14:8] byte_index,
                                                   // [16:15] status, [24:17] packet_total,
                                                   // [32:25] packet_flag, [39:33] zero
   output      logic                  rsp_tuser,   // [0] kind (0 byte, 1 end)

   // timeout_ticks register write
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [15:0]           csr_data
);

   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   logic    parse_push;
   logic    item_valid;
   rsp_type parse_result;
   rsp_type q_head;

   // front end takes a transfer whenever the queue has room, even if the
   // output register is still holding a result
   assign req_tready = !q_full;
   assign item_valid = req_tvalid && req_tready;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // parser: all frame state lives here, one item resolved per cycle while the queue has room
   fpr_parser #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .action     (req_tuser),
      .rx_byte    (req_tdata),
      .cfg_write  (csr_valid),
      .cfg_data   (csr_data),
      .push       (parse_push),
      .result     (parse_result)
   );

   // queue decouples the parser from output backpressure
   fpr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_push),
      .push_data (parse_result),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // output register packs the result onto the stream
   fpr_out u_out (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire
